/* rtl/hgid_pkg.sv */
// Shared types and constants for the hash group id assigner.
// No dependencies; imported by every module of the block but hgid_ram.
`timescale 1ns / 1ps

package hgid_pkg;

    // Default sizing of the slot table, group stores and key compare
    localparam int TABLE_SIZE_DEF = 1024;
    localparam int MAX_GROUPS_DEF = 768;
    localparam int KEY_BITS_DEF   = 64;

    // Fixed field widths of the request and result channels
    localparam int HASH_W         = 64;
    localparam int KEY_W          = 64;
    localparam int GROUP_NUMBER_W = 10;

    // Result handed from the probe controller to the output register
    typedef struct packed {
        logic [GROUP_NUMBER_W-1:0] group_number;
        logic                      is_new_group;
        logic                      table_full;
    } result_t;

endpackage

/* rtl/hash_group_id_assigner_unit.sv */
// A request is taken in the idle state and its first slot is read; an empty slot gives
// the result at once, an occupied slot adds a group store read, and each further probe
// adds a slot read, then a group store read. The probe walk is one shared sequencer, so
// a new request is taken only after the last result goes to the output register. A
// restart request adds a slot table clearing pass. Reset: synchronous, active low; a
// clearing pass follows with s_ready low, leaving the table empty and the group count zero.
`timescale 1ns / 1ps

module hash_group_id_assigner_unit #(
    parameter int TABLE_SIZE = hgid_pkg::TABLE_SIZE_DEF,
    parameter int MAX_GROUPS = hgid_pkg::MAX_GROUPS_DEF,
    parameter int KEY_BITS   = hgid_pkg::KEY_BITS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [hgid_pkg::HASH_W-1:0]           s_row_hash,
    input  logic [hgid_pkg::KEY_W-1:0]            s_row_key,
    input  logic                                  s_restart,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [hgid_pkg::GROUP_NUMBER_W-1:0]   m_group_number,
    output logic                                  m_is_new_group,
    output logic                                  m_table_full
);

    import hgid_pkg::*;

    localparam int IDX_BITS   = $clog2(TABLE_SIZE);
    localparam int GRP_BITS   = $clog2(MAX_GROUPS + 1);
    localparam int GADDR_BITS = $clog2(MAX_GROUPS);
    localparam int STORE_W    = HASH_W + KEY_BITS;

    logic                  slot_we;
    logic [IDX_BITS-1:0]   slot_waddr;
    logic [GRP_BITS-1:0]   slot_wdata;
    logic [IDX_BITS-1:0]   slot_raddr;
    logic [GRP_BITS-1:0]   slot_rdata;
    logic                  grp_we;
    logic [GADDR_BITS-1:0] grp_waddr;
    logic [STORE_W-1:0]    grp_wdata;
    logic [GADDR_BITS-1:0] grp_raddr;
    logic [STORE_W-1:0]    grp_rdata;
    logic                  res_valid;
    logic                  res_ready;
    result_t               res;

    // Slot table: group number per slot, zero when empty
    hgid_ram #(
        .WIDTH (GRP_BITS),
        .DEPTH (TABLE_SIZE)
    ) u_slot_ram (
        .aclk  (aclk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    // Group store: hash and key of each opened group
    hgid_ram #(
        .WIDTH (STORE_W),
        .DEPTH (MAX_GROUPS)
    ) u_grp_ram (
        .aclk  (aclk),
        .we    (grp_we),
        .waddr (grp_waddr),
        .wdata (grp_wdata),
        .raddr (grp_raddr),
        .rdata (grp_rdata)
    );

    // Probe sequencer
    hgid_probe_ctrl #(
        .TABLE_SIZE (TABLE_SIZE),
        .MAX_GROUPS (MAX_GROUPS),
        .KEY_BITS   (KEY_BITS)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_row_hash (s_row_hash),
        .s_row_key  (s_row_key),
        .s_restart  (s_restart),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .slot_we    (slot_we),
        .slot_waddr (slot_waddr),
        .slot_wdata (slot_wdata),
        .slot_raddr (slot_raddr),
        .slot_rdata (slot_rdata),
        .grp_we     (grp_we),
        .grp_waddr  (grp_waddr),
        .grp_wdata  (grp_wdata),
        .grp_raddr  (grp_raddr),
        .grp_rdata  (grp_rdata)
    );

    // Result output register
    hgid_out_reg u_out (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .res_valid      (res_valid),
        .res_ready      (res_ready),
        .res            (res),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_group_number (m_group_number),
        .m_is_new_group (m_is_new_group),
        .m_table_full   (m_table_full)
    );

endmodule

/* rtl/hgid_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module hgid_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

/* rtl/hgid_probe_ctrl.sv */
// Probe sequencer: clears the slot table, walks triangular probes and
// assigns dense group numbers. Depends on hgid_pkg; drives both RAMs.
`timescale 1ns / 1ps

module hgid_probe_ctrl #(
    parameter int TABLE_SIZE = 1024,
    parameter int MAX_GROUPS = 768,
    parameter int KEY_BITS   = 64
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    // request channel
    input  logic                                      s_valid,
    output logic                                      s_ready,
    input  logic [hgid_pkg::HASH_W-1:0]               s_row_hash,
    input  logic [hgid_pkg::KEY_W-1:0]                s_row_key,
    input  logic                                      s_restart,
    // result toward the output register
    output logic                                      res_valid,
    input  logic                                      res_ready,
    output hgid_pkg::result_t                         res,
    // slot table RAM
    output logic                                      slot_we,
    output logic [$clog2(TABLE_SIZE)-1:0]             slot_waddr,
    output logic [$clog2(MAX_GROUPS+1)-1:0]           slot_wdata,
    output logic [$clog2(TABLE_SIZE)-1:0]             slot_raddr,
    input  logic [$clog2(MAX_GROUPS+1)-1:0]           slot_rdata,
    // group hash/key store RAM
    output logic                                      grp_we,
    output logic [$clog2(MAX_GROUPS)-1:0]             grp_waddr,
    output logic [hgid_pkg::HASH_W+KEY_BITS-1:0]      grp_wdata,
    output logic [$clog2(MAX_GROUPS)-1:0]             grp_raddr,
    input  logic [hgid_pkg::HASH_W+KEY_BITS-1:0]      grp_rdata
);

    import hgid_pkg::*;

    localparam int IDX_BITS   = $clog2(TABLE_SIZE);
    localparam int GRP_BITS   = $clog2(MAX_GROUPS + 1);
    localparam int GADDR_BITS = $clog2(MAX_GROUPS);
    localparam int PRB_BITS   = IDX_BITS + 1;

    localparam logic [GRP_BITS-1:0] MAX_G     = GRP_BITS'(MAX_GROUPS);
    localparam logic [PRB_BITS-1:0] PROBE_END = PRB_BITS'(TABLE_SIZE);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_ISSUE  = 3'd2;
    localparam logic [2:0] ST_SLOT   = 3'd3;
    localparam logic [2:0] ST_GRP    = 3'd4;
    localparam logic [2:0] ST_RESULT = 3'd5;

    logic [2:0]          state_reg, state_next;
    logic [IDX_BITS-1:0] clr_reg, clr_next;
    logic                pend_reg, pend_next;
    logic [GRP_BITS-1:0] count_reg, count_next;
    logic [HASH_W-1:0]   hash_reg, hash_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [IDX_BITS-1:0] idx_reg, idx_next;
    logic [PRB_BITS-1:0] probe_reg, probe_next;
    logic [GRP_BITS-1:0] entry_reg, entry_next;
    result_t             res_reg, res_next;

    logic                accept;
    logic [PRB_BITS-1:0] probe_inc;
    logic [IDX_BITS-1:0] idx_step;
    logic [GRP_BITS-1:0] count_inc;
    logic [GRP_BITS-1:0] entry_m1;
    logic [31:0]         count_inc_w;
    logic [31:0]         entry_w;
    logic                grp_hit;

    // Datapath helpers
    assign accept      = s_valid && s_ready;
    assign s_ready     = (state_reg == ST_IDLE);
    assign probe_inc   = probe_reg + 1'b1;
    assign idx_step    = idx_reg + probe_inc[IDX_BITS-1:0];
    assign count_inc   = count_reg + 1'b1;
    assign entry_m1    = slot_rdata - 1'b1;
    assign count_inc_w = 32'(count_inc);
    assign entry_w     = 32'(entry_reg);
    assign grp_hit     = (grp_rdata == {hash_reg, key_reg});

    assign grp_raddr = entry_m1[GADDR_BITS-1:0];
    assign grp_waddr = count_reg[GADDR_BITS-1:0];
    assign grp_wdata = {hash_reg, key_reg};

    assign res_valid = (state_reg == ST_RESULT);
    assign res       = res_reg;

    // Sequence clear, probe and result hand-off
    always_comb begin
        state_next = state_reg;
        clr_next   = clr_reg;
        pend_next  = pend_reg;
        count_next = count_reg;
        hash_next  = hash_reg;
        key_next   = key_reg;
        idx_next   = idx_reg;
        probe_next = probe_reg;
        entry_next = entry_reg;
        res_next   = res_reg;
        slot_we    = 1'b0;
        slot_waddr = idx_reg;
        slot_wdata = count_inc;
        slot_raddr = idx_reg;
        grp_we     = 1'b0;

        case (state_reg)
            ST_CLEAR: begin
                slot_we    = 1'b1;
                slot_waddr = clr_reg;
                slot_wdata = '0;
                clr_next   = clr_reg + 1'b1;
                if (&clr_reg) begin
                    state_next = pend_reg ? ST_ISSUE : ST_IDLE;
                    pend_next  = 1'b0;
                end
            end
            ST_IDLE: begin
                slot_raddr = s_row_hash[IDX_BITS-1:0];
                if (accept) begin
                    hash_next  = s_row_hash;
                    key_next   = s_row_key[KEY_BITS-1:0];
                    idx_next   = s_row_hash[IDX_BITS-1:0];
                    probe_next = '0;
                    if (s_restart) begin
                        count_next = '0;
                        clr_next   = '0;
                        pend_next  = 1'b1;
                        state_next = ST_CLEAR;
                    end else begin
                        state_next = ST_SLOT;
                    end
                end
            end
            ST_ISSUE: begin
                state_next = ST_SLOT;
            end
            ST_SLOT: begin
                if (slot_rdata == '0) begin
                    // Empty slot: open a group unless the limit is reached
                    if (count_reg < MAX_G) begin
                        slot_we    = 1'b1;
                        grp_we     = 1'b1;
                        count_next = count_inc;
                        res_next   = '{group_number: count_inc_w[GROUP_NUMBER_W-1:0],
                                       is_new_group: 1'b1, table_full: 1'b0};
                    end else begin
                        res_next = '{group_number: '0, is_new_group: 1'b0,
                                     table_full: 1'b1};
                    end
                    state_next = ST_RESULT;
                end else begin
                    entry_next = slot_rdata;
                    state_next = ST_GRP;
                end
            end
            ST_GRP: begin
                if (grp_hit) begin
                    res_next   = '{group_number: entry_w[GROUP_NUMBER_W-1:0],
                                   is_new_group: 1'b0, table_full: 1'b0};
                    state_next = ST_RESULT;
                end else begin
                    probe_next = probe_inc;
                    if (probe_inc == PROBE_END) begin
                        res_next   = '{group_number: '0, is_new_group: 1'b0,
                                       table_full: 1'b1};
                        state_next = ST_RESULT;
                    end else begin
                        // Advance to the next triangular offset
                        idx_next   = idx_step;
                        slot_raddr = idx_step;
                        state_next = ST_SLOT;
                    end
                end
            end
            ST_RESULT: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            pend_reg  <= 1'b0;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            pend_reg  <= pend_next;
            count_reg <= count_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        hash_reg  <= hash_next;
        key_reg   <= key_next;
        idx_reg   <= idx_next;
        probe_reg <= probe_next;
        entry_reg <= entry_next;
        res_reg   <= res_next;
    end

`ifndef NO_ASSERTIONS
    a_count_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= MAX_G)
        else $error("group count above limit");

    a_slot_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (slot_we && state_reg != ST_CLEAR) |-> (slot_wdata != '0))
        else $error("slot written empty outside a clearing pass");

    a_grp_with_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        grp_we |-> (slot_we && slot_waddr == idx_reg))
        else $error("group store written without its slot");

    a_restart_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_restart) |=> (state_reg == ST_CLEAR && count_reg == '0))
        else $error("restart did not start a clearing pass");

    a_result_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> !(res.is_new_group && res.table_full))
        else $error("new group and refusal flagged together");
`endif

endmodule

/* rtl/hgid_out_reg.sv */
// Output register for the result channel; frees the sequencer while a
// result waits. Depends on hgid_pkg.
`timescale 1ns / 1ps

module hgid_out_reg (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  res_valid,
    output logic                                  res_ready,
    input  hgid_pkg::result_t                     res,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [hgid_pkg::GROUP_NUMBER_W-1:0]   m_group_number,
    output logic                                  m_is_new_group,
    output logic                                  m_table_full
);

    import hgid_pkg::*;

    logic    valid_reg, valid_next;
    result_t data_reg;
    logic    load;

    // Load when empty or when the held result leaves this cycle
    assign res_ready = !valid_reg || m_ready;
    assign load      = res_valid && res_ready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Hold the result payload
    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= res;
        end
    end

    assign m_valid        = valid_reg;
    assign m_group_number = data_reg.group_number;
    assign m_is_new_group = data_reg.is_new_group;
    assign m_table_full   = data_reg.table_full;

endmodule
